// ===== rtl/idm_pkg.sv =====
// Shared types and constants for the integer divide/modulo core.
// Used by idm_pre, idm_cell, idm_post and int_divide_modulo_zero_safe_core.
`timescale 1ns / 1ps

package idm_pkg;

    // Operand and result width.
    localparam int DATA_W = 32;

    // Request type codes carried on s_tuser.
    localparam logic REQ_SIGNED   = 1'b0;
    localparam logic REQ_UNSIGNED = 1'b1;

    typedef logic [DATA_W-1:0] word_t;

    // Work item handed from cell to cell along the divider row.
    typedef struct packed {
        word_t rem;       // partial remainder
        word_t quo;       // dividend bits still to be consumed, quotient bits shifted in
        word_t den;       // divisor magnitude
        word_t num;       // original dividend, returned on a zero divisor
        logic  neg_q;     // negate the quotient at the end
        logic  neg_r;     // negate the remainder at the end
        logic  div_zero;  // divisor was zero
    } idm_work_t;

endpackage

// ===== rtl/int_divide_modulo_zero_safe_core.sv =====
// Pipeline: input stage, 32 division cells and output stage, each one a registered stage.
// Throughput: one division per cycle unless m_tready stalls; each quotient bit is settled by its own cell in the row.
// Every stage takes a new item when empty or when its content moves on, so bubbles close up.
// Reset (aresetn low, synchronous) clears all valid flags; results in flight are dropped.
// Depends on idm_pkg, idm_pre, idm_cell and idm_post.
`timescale 1ns / 1ps

module int_divide_modulo_zero_safe_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [2*idm_pkg::DATA_W-1:0] s_tdata,  // [31:0] dividend, [63:32] divisor
    input  logic                       s_tuser,   // [0] req_type
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [2*idm_pkg::DATA_W-1:0] m_tdata   // [31:0] quotient, [63:32] remainder
);

    logic               link_valid [idm_pkg::DATA_W+1];
    logic               link_ready [idm_pkg::DATA_W+1];
    idm_pkg::idm_work_t link_data  [idm_pkg::DATA_W+1];
    idm_pkg::word_t     quotient;
    idm_pkg::word_t     remainder;

    // Operand preparation.
    idm_pre u_pre (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .req_type  (s_tuser),
        .dividend  (s_tdata[idm_pkg::DATA_W-1:0]),
        .divisor   (s_tdata[2*idm_pkg::DATA_W-1:idm_pkg::DATA_W]),
        .out_valid (link_valid[0]),
        .out_ready (link_ready[0]),
        .out_data  (link_data[0])
    );

    // Row of division cells, most significant quotient bit first.
    for (genvar i = 0; i < idm_pkg::DATA_W; i++) begin : g_cell
        idm_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (link_valid[i]),
            .in_ready  (link_ready[i]),
            .in_data   (link_data[i]),
            .out_valid (link_valid[i+1]),
            .out_ready (link_ready[i+1]),
            .out_data  (link_data[i+1])
        );
    end

    // Sign correction and result register.
    idm_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (link_valid[idm_pkg::DATA_W]),
        .in_ready  (link_ready[idm_pkg::DATA_W]),
        .in_data   (link_data[idm_pkg::DATA_W]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .quotient  (quotient),
        .remainder (remainder)
    );

    assign m_tdata = {remainder, quotient};

endmodule

// ===== rtl/idm_pre.sv =====
// Input stage of the divider: takes operand magnitudes and flags special cases.
// Depends on idm_pkg.
`timescale 1ns / 1ps

module idm_pre (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               req_type,
    input  idm_pkg::word_t     dividend,
    input  idm_pkg::word_t     divisor,
    output logic               out_valid,
    input  logic               out_ready,
    output idm_pkg::idm_work_t out_data
);

    logic               valid_reg;
    logic               valid_next;
    idm_pkg::idm_work_t data_reg;
    idm_pkg::idm_work_t data_next;
    logic               sn;
    logic               sd;
    idm_pkg::word_t     mn;
    idm_pkg::word_t     md;

    // The stage takes a new item when empty or when its content moves on.
    assign in_ready = !valid_reg || out_ready;

    // Signs and magnitudes; the most negative value keeps its own pattern.
    always_comb begin
        sn = (req_type == idm_pkg::REQ_SIGNED) && dividend[idm_pkg::DATA_W-1];
        sd = (req_type == idm_pkg::REQ_SIGNED) && divisor[idm_pkg::DATA_W-1];
        mn = sn ? (-dividend) : dividend;
        md = sd ? (-divisor) : divisor;
        data_next.rem      = '0;
        data_next.quo      = mn;
        data_next.den      = md;
        data_next.num      = dividend;
        data_next.neg_q    = sn ^ sd;
        data_next.neg_r    = sn;
        data_next.div_zero = (divisor == '0);
        valid_next         = in_ready ? in_valid : valid_reg;
    end

    // Valid flag under reset; payload loads on each transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/idm_cell.sv =====
// One restoring-division cell: resolves a single quotient bit and registers it.
// Depends on idm_pkg.
`timescale 1ns / 1ps

module idm_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  idm_pkg::idm_work_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output idm_pkg::idm_work_t out_data
);

    logic                    valid_reg;
    logic                    valid_next;
    idm_pkg::idm_work_t      data_reg;
    idm_pkg::idm_work_t      data_next;
    logic [idm_pkg::DATA_W:0] shifted;
    logic [idm_pkg::DATA_W:0] trial;

    assign in_ready = !valid_reg || out_ready;

    // Shift in the next dividend bit and try subtracting the divisor.
    always_comb begin
        shifted   = {in_data.rem, in_data.quo[idm_pkg::DATA_W-1]};
        trial     = shifted - {1'b0, in_data.den};
        data_next = in_data;
        if (!trial[idm_pkg::DATA_W]) begin
            data_next.rem = trial[idm_pkg::DATA_W-1:0];
            data_next.quo = {in_data.quo[idm_pkg::DATA_W-2:0], 1'b1};
        end else begin
            data_next.rem = shifted[idm_pkg::DATA_W-1:0];
            data_next.quo = {in_data.quo[idm_pkg::DATA_W-2:0], 1'b0};
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    // Valid flag under reset; payload loads on each transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/idm_post.sv =====
// Output stage of the divider: applies signs and the zero-divisor rule, holds the result.
// Depends on idm_pkg.
`timescale 1ns / 1ps

module idm_post (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  idm_pkg::idm_work_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output idm_pkg::word_t     quotient,
    output idm_pkg::word_t     remainder
);

    logic           valid_reg;
    logic           valid_next;
    idm_pkg::word_t quo_reg;
    idm_pkg::word_t quo_next;
    idm_pkg::word_t rem_reg;
    idm_pkg::word_t rem_next;

    assign in_ready = !valid_reg || out_ready;

    // A zero divisor returns the dividend with a zero remainder.
    always_comb begin
        if (in_data.div_zero) begin
            quo_next = in_data.num;
            rem_next = '0;
        end else begin
            quo_next = in_data.neg_q ? (-in_data.quo) : in_data.quo;
            rem_next = in_data.neg_r ? (-in_data.rem) : in_data.rem;
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    // Result register; it holds while the downstream side stalls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (in_valid && in_ready) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign out_valid = valid_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== tb/tb_int_divide_modulo_zero_safe_core.sv =====
// Self-checking testbench for int_divide_modulo_zero_safe_core: directed and random divisions
// with random idling on both stream sides, checked against a quotient/remainder predictor.
// Depends on idm_pkg and the divider RTL.
`timescale 1ns / 1ps

module tb_int_divide_modulo_zero_safe_core;

    // Predicts quotient and remainder for each accepted request and checks the results in order.
    class divide_checker;
        idm_pkg::word_t quo_pending[$];
        idm_pkg::word_t rem_pending[$];
        int             errors;

        function new();
            errors = 0;
        endfunction

        // Zero-divisor-safe divide: signed mode truncates toward zero and wraps on overflow.
        function void divide_words(input logic rt, input idm_pkg::word_t a,
                                   input idm_pkg::word_t b,
                                   output idm_pkg::word_t q, output idm_pkg::word_t r);
            logic           sn;
            logic           sd;
            idm_pkg::word_t mn;
            idm_pkg::word_t md;
            idm_pkg::word_t mq;
            idm_pkg::word_t mr;
            if (b == '0) begin
                q = a;
                r = '0;
            end else if (rt == idm_pkg::REQ_UNSIGNED) begin
                q = a / b;
                r = a % b;
            end else begin
                sn = a[idm_pkg::DATA_W-1];
                sd = b[idm_pkg::DATA_W-1];
                // The most negative value negates to itself, which is its magnitude here.
                mn = sn ? idm_pkg::word_t'(-a) : a;
                md = sd ? idm_pkg::word_t'(-b) : b;
                mq = mn / md;
                mr = mn % md;
                q  = (sn != sd) ? idm_pkg::word_t'(-mq) : mq;
                r  = sn ? idm_pkg::word_t'(-mr) : mr;
            end
        endfunction

        function void note_request(input logic rt, input idm_pkg::word_t a,
                                   input idm_pkg::word_t b);
            idm_pkg::word_t q;
            idm_pkg::word_t r;
            divide_words(rt, a, b, q, r);
            quo_pending.push_back(q);
            rem_pending.push_back(r);
        endfunction

        function void check_result(input logic [2*idm_pkg::DATA_W-1:0] data);
            idm_pkg::word_t q;
            idm_pkg::word_t r;
            if (quo_pending.size() == 0) begin
                $error("result %h arrived with no request outstanding", data);
                errors++;
                return;
            end
            q = quo_pending.pop_front();
            r = rem_pending.pop_front();
            if (data[idm_pkg::DATA_W-1:0] !== q) begin
                $error("quotient: expected %h, actual %h", q, data[idm_pkg::DATA_W-1:0]);
                errors++;
            end
            if (data[2*idm_pkg::DATA_W-1:idm_pkg::DATA_W] !== r) begin
                $error("remainder: expected %h, actual %h", r,
                       data[2*idm_pkg::DATA_W-1:idm_pkg::DATA_W]);
                errors++;
            end
        endfunction

        function int pending();
            return quo_pending.size();
        endfunction
    endclass

    logic                         aclk     = 1'b0;
    logic                         aresetn  = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [2*idm_pkg::DATA_W-1:0] s_tdata  = '0;  // [31:0] dividend, [63:32] divisor
    logic                         s_tuser  = idm_pkg::REQ_SIGNED;  // [0] req_type
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [2*idm_pkg::DATA_W-1:0] m_tdata;  // [31:0] quotient, [63:32] remainder

    divide_checker sb = new();
    bit            idle_on = 1'b1;

    localparam int RANDOM_ITEMS = 1400;
    localparam int QUIET_ITEMS  = 300;
    localparam int DRAIN_CYCLES = 50;

    int_divide_modulo_zero_safe_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // 12 ns clock.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Watch both channels at the rising edge and record every transfer.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_request(s_tuser, s_tdata[idm_pkg::DATA_W-1:0],
                                s_tdata[2*idm_pkg::DATA_W-1:idm_pkg::DATA_W]);
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
        end
    end

    // Result side: ready most of the time, with random stall bursts while idling is on.
    initial begin
        int stall;
        forever begin
            @(negedge aclk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 13);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Present one request and hold it until it is transferred, sometimes after an idle gap.
    task automatic send_div(input logic rt, input idm_pkg::word_t a, input idm_pkg::word_t b);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 13);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tuser  <= rt;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Operands drawn from a mix of edge values, small numbers and full-range patterns.
    function automatic idm_pkg::word_t pick_operand(input bit allow_zero);
        case ($urandom_range(0, 9))
            0: return allow_zero ? idm_pkg::word_t'(0) : idm_pkg::word_t'(1);
            1: begin
                case ($urandom_range(0, 4))
                    0: return idm_pkg::word_t'(1);
                    1: return '1;
                    2: return {1'b1, {(idm_pkg::DATA_W-1){1'b0}}};
                    3: return {1'b0, {(idm_pkg::DATA_W-1){1'b1}}};
                    default: return {1'b1, {(idm_pkg::DATA_W-2){1'b0}}, 1'b1};
                endcase
            end
            2, 3: return idm_pkg::word_t'($urandom_range(1, 100));
            4: return idm_pkg::word_t'(-$urandom_range(1, 100));
            5: return idm_pkg::word_t'($urandom) >> $urandom_range(0, idm_pkg::DATA_W-1);
            default: return idm_pkg::word_t'($urandom);
        endcase
    endfunction

    initial begin
        logic           rt;
        idm_pkg::word_t a;
        idm_pkg::word_t b;
        idm_pkg::word_t dir_a[$];
        idm_pkg::word_t dir_b[$];
        logic           dir_t[$];

        // Directed cases: zero divisors, signed overflow, sign combinations, width extremes.
        dir_t = '{idm_pkg::REQ_SIGNED, idm_pkg::REQ_UNSIGNED, idm_pkg::REQ_SIGNED,
                  idm_pkg::REQ_UNSIGNED, idm_pkg::REQ_SIGNED, idm_pkg::REQ_SIGNED,
                  idm_pkg::REQ_SIGNED, idm_pkg::REQ_SIGNED, idm_pkg::REQ_SIGNED,
                  idm_pkg::REQ_SIGNED, idm_pkg::REQ_SIGNED, idm_pkg::REQ_SIGNED,
                  idm_pkg::REQ_UNSIGNED, idm_pkg::REQ_UNSIGNED, idm_pkg::REQ_UNSIGNED,
                  idm_pkg::REQ_UNSIGNED, idm_pkg::REQ_UNSIGNED,
                  idm_pkg::REQ_SIGNED, idm_pkg::REQ_SIGNED, idm_pkg::REQ_UNSIGNED};
        dir_a = '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFF9,
                  32'h0000_0007, 32'hFFFF_FFF9, 32'h8000_0000, 32'h0000_0001,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0064,
                  32'h0000_0003, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        dir_b = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                  32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002,
                  32'hFFFF_FFFE, 32'hFFFF_FFFE, 32'h8000_0000, 32'h8000_0000,
                  32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0002, 32'h0000_0007,
                  32'h0000_000A, 32'h7FFF_FFFF, 32'h0000_0003, 32'h8000_0000};

        // Synchronous reset held at start, then released.
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_a[i]) send_div(dir_t[i], dir_a[i], dir_b[i]);

        // Random requests; the final stretch runs with no idling on either side.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS) idle_on = 1'b0;
            rt = $urandom_range(0, 1) ? idm_pkg::REQ_UNSIGNED : idm_pkg::REQ_SIGNED;
            a  = pick_operand(1'b1);
            b  = ($urandom_range(0, 19) == 0) ? idm_pkg::word_t'(0) : pick_operand(1'b0);
            send_div(rt, a, b);
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        // Drain the pipeline, then watch a while longer for stray results.
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("int_divide_modulo_zero_safe_core: match");
        end else begin
            $display("int_divide_modulo_zero_safe_core: mismatch");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #4_000_000;
        $display("int_divide_modulo_zero_safe_core: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/idm_pkg.sv
rtl/idm_pre.sv
rtl/idm_cell.sv
rtl/idm_post.sv
rtl/int_divide_modulo_zero_safe_core.sv
tb/tb_int_divide_modulo_zero_safe_core.sv
